[hdl/pbp_pkg.sv]
// shared types, constants and codes of the perceptron branch predictor
package pbp_pkg;

    // number of weights, one per history bit
    localparam int NUM_WEIGHTS = 64;
    localparam int HIST_W      = 64;
    localparam int WEIGHT_W    = 8;
    localparam int SUM_W       = 14;
    localparam int MAG_W       = 13;
    localparam int BOUND_W     = 7;
    localparam int THR_W       = 13;
    localparam int OUT_DATA_W  = 24;

    // adder tree shape, padded to a power of two
    localparam int TREE_LEVELS = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 0;
    localparam int TREE_SIZE   = 1 << TREE_LEVELS;

    // configuration register indexes
    localparam logic [1:0] CFG_WEIGHT_BOUND     = 2'd0;
    localparam logic [1:0] CFG_TRAIN_THRESHOLD  = 2'd1;
    localparam logic [1:0] CFG_CONFIDENCE_BOUND = 2'd2;

    // reset values of the configuration registers
    localparam logic [BOUND_W-1:0] WEIGHT_BOUND_RST     = 7'd127;
    localparam logic [THR_W-1:0]   TRAIN_THRESHOLD_RST  = 13'd137;
    localparam logic [THR_W-1:0]   CONFIDENCE_BOUND_RST = 13'd0;

    // operation codes
    typedef enum logic [1:0] {
        OP_PREDICT = 2'd0,
        OP_TRAIN   = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef weight_t [NUM_WEIGHTS-1:0]  weight_vec_t;

    // configuration register contents
    typedef struct packed {
        logic [BOUND_W-1:0] weight_bound;
        logic [THR_W-1:0]   train_threshold;
        logic [THR_W-1:0]   confidence_bound;
    } cfg_t;

    // weight update request
    typedef struct packed {
        logic train;
        logic clear;
    } upd_t;

    // one result item
    typedef struct packed {
        logic                    trained;
        logic                    confident;
        logic                    taken;
        logic signed [SUM_W-1:0] weighted_sum;
    } res_t;

endpackage

[hdl/pbp_cfg_regs.sv]
// configuration registers of the perceptron branch predictor
module pbp_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    output pbp_pkg::cfg_t      cfg
);
    import pbp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // decode the register index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WEIGHT_BOUND:     cfg_next.weight_bound     = cfg_data[BOUND_W-1:0];
                CFG_TRAIN_THRESHOLD:  cfg_next.train_threshold  = cfg_data[THR_W-1:0];
                CFG_CONFIDENCE_BOUND: cfg_next.confidence_bound = cfg_data[THR_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // register state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight_bound     <= WEIGHT_BOUND_RST;
            cfg_reg.train_threshold  <= TRAIN_THRESHOLD_RST;
            cfg_reg.confidence_bound <= CONFIDENCE_BOUND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/pbp_weight_file.sv]
// weight registers with saturating training update and clear
module pbp_weight_file
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pbp_pkg::upd_t               upd,
    input  logic [pbp_pkg::HIST_W-1:0]  history,
    input  logic [pbp_pkg::BOUND_W-1:0] weight_bound,
    output pbp_pkg::weight_vec_t        weights
);
    import pbp_pkg::*;

    weight_vec_t weights_reg;
    weight_vec_t weights_next;

    // per-weight step and clamp, every weight in parallel
    always_comb
    begin
        logic signed [WEIGHT_W:0] bnd;
        logic signed [WEIGHT_W:0] w;
        bnd = signed'({2'b00, weight_bound});
        weights_next = weights_reg;
        for (int i = 0; i < NUM_WEIGHTS; i++)
        begin
            w = {weights_reg[i][WEIGHT_W-1], weights_reg[i]};
            if (history[i])
            begin
                w = w + 9'sd1;
            end
            else
            begin
                w = w - 9'sd1;
            end
            if (w > bnd)
            begin
                w = bnd;
            end
            if (w < -bnd)
            begin
                w = -bnd;
            end
            if (upd.clear)
            begin
                weights_next[i] = '0;
            end
            else if (upd.train)
            begin
                weights_next[i] = w[WEIGHT_W-1:0];
            end
        end
    end

    // weight storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg <= '0;
        end
        else
        begin
            weights_reg <= weights_next;
        end
    end

    assign weights = weights_reg;

endmodule

[hdl/pbp_predict.sv]
// weighted sum adder tree and predict/train decision
module pbp_predict
(
    input  pbp_pkg::weight_vec_t       weights,
    input  logic [pbp_pkg::HIST_W-1:0] history,
    input  pbp_pkg::op_t               op,
    input  pbp_pkg::cfg_t              cfg,
    output pbp_pkg::res_t              res,
    output pbp_pkg::upd_t              upd
);
    import pbp_pkg::*;

    logic signed [SUM_W-1:0] tree [TREE_LEVELS+1][TREE_SIZE];
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        abs_sum;
    logic [MAG_W-1:0]        mag;
    logic                    taken;
    logic                    confident;
    logic                    skip;

    // balanced adder tree over the selected weights
    always_comb
    begin
        tree = '{default: '0};
        for (int i = 0; i < TREE_SIZE; i++)
        begin
            if (i < NUM_WEIGHTS)
            begin
                if (history[i])
                begin
                    tree[0][i] = SUM_W'(weights[i]);
                end
            end
        end
        for (int lvl = 0; lvl < TREE_LEVELS; lvl++)
        begin
            for (int i = 0; i < (TREE_SIZE >> (lvl + 1)); i++)
            begin
                tree[lvl+1][i] = tree[lvl][2*i] + tree[lvl][2*i+1];
            end
        end
    end

    assign sum     = tree[TREE_LEVELS][0];
    assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    assign mag     = abs_sum[MAG_W-1:0];

    // decisions on the sum before any update
    assign taken     = (sum > 0);
    assign confident = (mag > cfg.confidence_bound);
    assign skip      = (confident && (taken == history[0])) ||
                       (mag > cfg.train_threshold);

    // update request by operation
    always_comb
    begin
        upd = '0;
        case (op)
            OP_TRAIN: upd.train = !skip;
            OP_CLEAR: upd.clear = 1'b1;
            default:  upd = '0;
        endcase
    end

    assign res.weighted_sum = sum;
    assign res.taken        = taken;
    assign res.confident    = confident;
    assign res.trained      = upd.train;

endmodule

[hdl/perceptron_branch_predictor_unit.sv]
// top level of the perceptron branch predictor
//
// Usage: items arrive on the s_ stream, one per transfer; s_tuser carries the
// operation (predict, train, clear) and s_tdata the 64-bit history word, with
// the branch outcome in bit 0 for a train. Every item gives exactly one result
// on the m_ stream: the weighted sum of the weights as they stood before the
// item, the taken and confident flags, and whether a train updated weights.
// The item sits in the input register while the adder tree sums the 64 weights,
// then moves to the result register, which drives m_tvalid. Throughput is one
// item per cycle while the receiver does not stall; a train or clear writes the
// weights at the same edge that loads the result register, so the next item
// already sees the new weights. When the receiver stalls, the result is held
// and one further item waits in the input register before s_tready drops.
// Reset zeroes all weights, empties both registers and loads the configuration
// defaults (weight bound 127, train threshold 137, confidence bound 0).
// Configuration writes on the cfg_ channel are taken in any cycle and should
// only be issued while no item is in flight.
module perceptron_branch_predictor_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] history
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [13:0] weighted_sum, [14] taken,
                                   // [15] confident, [16] trained, [23:17] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import pbp_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    op_t               op_reg;
    op_t               op_next;
    logic [HIST_W-1:0] hist_reg;
    logic [HIST_W-1:0] hist_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    res_t              res_reg;
    res_t              res_next;

    cfg_t        cfg;
    weight_vec_t weights;
    res_t        res;
    upd_t        upd;
    upd_t        upd_gated;
    logic        advance;
    logic        fire;

    // configuration registers
    pbp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sum and decision on the item in the input register
    pbp_predict u_predict
    (
        .weights (weights),
        .history (hist_reg),
        .op      (op_reg),
        .cfg     (cfg),
        .res     (res),
        .upd     (upd)
    );

    // weights change only when the item moves to the result register
    assign upd_gated.train = upd.train & fire;
    assign upd_gated.clear = upd.clear & fire;

    pbp_weight_file u_weights
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd          (upd_gated),
        .history      (hist_reg),
        .weight_bound (cfg.weight_bound),
        .weights      (weights)
    );

    // pipeline handshake
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        op_next        = op_reg;
        hist_next      = hist_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
            res_next       = res;
        end
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
            op_next       = op_t'(s_tuser);
            hist_next     = s_tdata;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        hist_reg <= hist_next;
        res_reg  <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg.trained, res_reg.confident, res_reg.taken,
                       res_reg.weighted_sum};

endmodule
